[rtl/str_pkg.sv]
// shared types and constants for the servo ramp interpolator
package str_pkg;

   localparam int WIDTH_W    = 12;
   localparam int OFFSET_W   = 13;
   localparam int TIME_W     = 15;
   localparam int STEP_W     = 11;
   localparam int PULSE_W    = 16;
   localparam int DEADBAND_W = 11;
   localparam int CHAN_W     = 3;
   localparam int OUT_CHANS  = 8;
   localparam int PROD_W     = WIDTH_W + STEP_W;
   localparam int BIT_CNT_W  = 4;

   localparam logic [PULSE_W-1:0] PULSE_MIN  = 16'd500;
   localparam logic [PULSE_W-1:0] PULSE_MAX  = 16'd2500;
   localparam logic [PULSE_W-1:0] TIME_MIN   = 16'd20;
   localparam logic [PULSE_W-1:0] TIME_MAX   = 16'd30000;
   localparam logic [TIME_W-1:0]  TIME_RESET = 15'd2000;
   localparam logic [WIDTH_W-1:0] WIDTH_MAX  = 12'd4095;

   // ramp_time / 20 as (ramp_time * RECIP_TICK) >> RECIP_SHIFT, exact below 2^15
   localparam logic [15:0] RECIP_TICK  = 16'd52429;
   localparam int          RECIP_SHIFT = 20;

   localparam logic [WIDTH_W-1:0] RESET_WIDTH [OUT_CHANS] = '{
      12'd1500, 12'd1500, 12'd1500, 12'd500, 12'd500, 12'd900, 12'd1500, 12'd1500
   };

   typedef enum logic [1:0] {
      OP_TICK  = 2'd0,
      OP_TIMED = 2'd1,
      OP_IMMED = 2'd2,
      OP_NONE  = 2'd3
   } opcode_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_LATCH,
      ST_STEP,
      ST_MUL,
      ST_DIV,
      ST_WRITE,
      ST_DONE
   } state_type;

   typedef enum logic [2:0] {
      DP_NONE,
      DP_ACCEPT,
      DP_LATCH,
      DP_STEP,
      DP_MUL,
      DP_DIV,
      DP_WRITE,
      DP_LOAD_RSP
   } dp_op_type;

   typedef struct packed {
      dp_op_type         op;
      logic [CHAN_W-1:0] chan;
   } cmd_type;

   typedef struct packed {
      logic running;
      logic last_step;
   } status_type;

endpackage

[rtl/str_req_if.sv]
// request channel: command items into the ramp block
interface str_req_if;
   import str_pkg::*;

   logic               valid;
   logic               ready;
   logic [1:0]         opcode;
   logic [CHAN_W-1:0]  channel;
   logic [PULSE_W-1:0] pulse_us;
   logic [PULSE_W-1:0] move_time_ms;

   modport source (output valid, output opcode, output channel, output pulse_us,
                   output move_time_ms, input ready);
   modport sink   (input valid, input opcode, input channel, input pulse_us,
                   input move_time_ms, output ready);
endinterface

[rtl/str_rsp_if.sv]
// response channel: status and channel widths out of the ramp block
interface str_rsp_if;
   import str_pkg::*;

   logic               valid;
   logic               ready;
   logic               accepted;
   logic               ramp_active;
   logic [WIDTH_W-1:0] duty_ch0;
   logic [WIDTH_W-1:0] duty_ch1;
   logic [WIDTH_W-1:0] duty_ch2;
   logic [WIDTH_W-1:0] duty_ch3;
   logic [WIDTH_W-1:0] duty_ch4;
   logic [WIDTH_W-1:0] duty_ch5;
   logic [WIDTH_W-1:0] duty_ch6;
   logic [WIDTH_W-1:0] duty_ch7;

   modport source (output valid, output accepted, output ramp_active,
                   output duty_ch0, output duty_ch1, output duty_ch2, output duty_ch3,
                   output duty_ch4, output duty_ch5, output duty_ch6, output duty_ch7,
                   input ready);
   modport sink   (input valid, input accepted, input ramp_active,
                   input duty_ch0, input duty_ch1, input duty_ch2, input duty_ch3,
                   input duty_ch4, input duty_ch5, input duty_ch6, input duty_ch7,
                   output ready);
endinterface

[rtl/str_ctrl.sv]
// sequencer for commands, tick latch, per-channel multiply and divide
module str_ctrl #(
   parameter int CHANNEL_COUNT = 8
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   input  logic [1:0]          req_opcode,
   output logic                req_ready,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   input  str_pkg::status_type status,
   output str_pkg::cmd_type    cmd
);
   import str_pkg::*;

   localparam int CH_W = (CHANNEL_COUNT > 1) ? $clog2(CHANNEL_COUNT) : 1;
   localparam logic [CH_W-1:0] LAST_CH = CH_W'(CHANNEL_COUNT - 1);
   localparam logic [BIT_CNT_W-1:0] LAST_BIT = BIT_CNT_W'(WIDTH_W - 1);

   state_type            state_ff, state_in;
   logic [CH_W-1:0]      ch_ff, ch_in;
   logic [BIT_CNT_W-1:0] bit_ff, bit_in;
   logic                 rsp_valid_ff, rsp_valid_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         ch_ff        <= '0;
         bit_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         ch_ff        <= ch_in;
         bit_ff       <= bit_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in     = state_ff;
      ch_in        = ch_ff;
      bit_in       = bit_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      req_ready    = 1'b0;
      cmd.op       = DP_NONE;
      cmd.chan     = CHAN_W'(ch_ff);
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.op = DP_ACCEPT;
               if (req_opcode == OP_TICK) begin
                  state_in = ST_LATCH;
               end else begin
                  state_in = ST_DONE;
               end
            end
         end
         ST_LATCH: begin
            cmd.op   = DP_LATCH;
            state_in = ST_STEP;
         end
         ST_STEP: begin
            cmd.op = DP_STEP;
            ch_in  = '0;
            if (status.running && !status.last_step) begin
               state_in = ST_MUL;
            end else begin
               state_in = ST_DONE;
            end
         end
         ST_MUL: begin
            cmd.op   = DP_MUL;
            bit_in   = '0;
            state_in = ST_DIV;
         end
         ST_DIV: begin
            cmd.op = DP_DIV;
            bit_in = bit_ff + 1'b1;
            if (bit_ff == LAST_BIT) begin
               state_in = ST_WRITE;
            end
         end
         ST_WRITE: begin
            cmd.op = DP_WRITE;
            if (ch_ff == LAST_CH) begin
               state_in = ST_DONE;
            end else begin
               ch_in    = ch_ff + 1'b1;
               state_in = ST_MUL;
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.op       = DP_LOAD_RSP;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

[rtl/str_dp.sv]
// channel widths, ramp state, shared multiply and restoring divider, output register
module str_dp #(
   parameter int CHANNEL_COUNT = 8
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   csr_we,
   input  logic [str_pkg::DEADBAND_W-1:0]         csr_wdata,
   input  logic [1:0]                             req_opcode,
   input  logic [str_pkg::CHAN_W-1:0]             req_channel,
   input  logic [str_pkg::PULSE_W-1:0]            req_pulse_us,
   input  logic [str_pkg::PULSE_W-1:0]            req_move_time_ms,
   input  str_pkg::cmd_type                       cmd,
   output str_pkg::status_type                    status,
   output logic                                   rsp_accepted,
   output logic                                   rsp_ramp_active,
   output logic [str_pkg::WIDTH_W-1:0]            rsp_duty [str_pkg::OUT_CHANS]
);
   import str_pkg::*;

   localparam int CH_W = (CHANNEL_COUNT > 1) ? $clog2(CHANNEL_COUNT) : 1;

   logic        [WIDTH_W-1:0]    cur_ff    [CHANNEL_COUNT];
   logic        [WIDTH_W-1:0]    cur_in    [CHANNEL_COUNT];
   logic        [WIDTH_W-1:0]    tgt_ff    [CHANNEL_COUNT];
   logic        [WIDTH_W-1:0]    tgt_in    [CHANNEL_COUNT];
   logic signed [OFFSET_W-1:0]   off_ff    [CHANNEL_COUNT];
   logic signed [OFFSET_W-1:0]   off_in    [CHANNEL_COUNT];
   logic        [TIME_W-1:0]     ramp_time_ff, ramp_time_in;
   logic        [STEP_W-1:0]     total_ff, total_in;
   logic        [STEP_W-1:0]     left_ff, left_in;
   logic                         pending_ff, pending_in;
   logic                         running_ff, running_in;
   logic        [DEADBAND_W-1:0] deadband_ff, deadband_in;
   logic                         acc_ff, acc_in;
   logic        [STEP_W-1:0]     rem_ff, rem_in;
   logic        [WIDTH_W-1:0]    dvd_ff, dvd_in;
   logic                         neg_ff, neg_in;
   logic                         rsp_acc_ff, rsp_acc_in;
   logic                         rsp_run_ff, rsp_run_in;
   logic        [WIDTH_W-1:0]    duty_ff   [OUT_CHANS];
   logic        [WIDTH_W-1:0]    duty_in   [OUT_CHANS];

   logic [CH_W-1:0]    req_idx;
   logic [CH_W-1:0]    ch_idx;
   logic               req_ok;
   logic [PULSE_W-1:0] old_tgt;
   logic [PULSE_W-1:0] diff_w;
   logic [PULSE_W-1:0] time_clamped;
   logic [STEP_W-1:0]  steps_raw;
   logic [STEP_W-1:0]  steps_w;
   logic [WIDTH_W-1:0] mag_w;
   logic [PROD_W-1:0]  prod_w;
   logic [STEP_W:0]    rem2_w;
   logic               div_ge;
   logic signed [WIDTH_W+1:0] sum_w;
   logic [WIDTH_W-1:0] sat_w;

   assign req_idx = req_channel[CH_W-1:0];
   assign ch_idx  = cmd.chan[CH_W-1:0];
   assign req_ok  = ({1'b0, req_channel} < (CHAN_W + 1)'(CHANNEL_COUNT))
                    && (req_pulse_us >= PULSE_MIN) && (req_pulse_us <= PULSE_MAX);
   assign old_tgt = {4'd0, tgt_ff[req_idx]};
   assign diff_w  = (old_tgt > req_pulse_us) ? (old_tgt - req_pulse_us)
                                             : (req_pulse_us - old_tgt);

   always_comb begin
      if (req_move_time_ms < TIME_MIN) begin
         time_clamped = TIME_MIN;
      end else if (req_move_time_ms > TIME_MAX) begin
         time_clamped = TIME_MAX;
      end else begin
         time_clamped = req_move_time_ms;
      end
   end

   assign steps_raw = 11'(({16'd0, ramp_time_ff} * {15'd0, RECIP_TICK}) >> RECIP_SHIFT);
   assign steps_w   = (steps_raw == '0) ? STEP_W'(1) : steps_raw;

   assign mag_w  = off_ff[ch_idx][OFFSET_W-1] ? WIDTH_W'(-off_ff[ch_idx])
                                              : off_ff[ch_idx][WIDTH_W-1:0];
   assign prod_w = {{STEP_W{1'b0}}, mag_w} * {{WIDTH_W{1'b0}}, left_ff};

   assign rem2_w = {rem_ff, dvd_ff[WIDTH_W-1]};
   assign div_ge = rem2_w >= {1'b0, total_ff};

   assign sum_w = neg_ff ? ($signed({2'b00, tgt_ff[ch_idx]}) - $signed({2'b00, dvd_ff}))
                         : ($signed({2'b00, tgt_ff[ch_idx]}) + $signed({2'b00, dvd_ff}));

   always_comb begin
      if (sum_w < 0) begin
         sat_w = '0;
      end else if (sum_w > $signed({2'b00, WIDTH_MAX})) begin
         sat_w = WIDTH_MAX;
      end else begin
         sat_w = sum_w[WIDTH_W-1:0];
      end
   end

   assign status.running   = running_ff;
   assign status.last_step = (left_ff <= STEP_W'(1));

   always_comb begin
      cur_in       = cur_ff;
      tgt_in       = tgt_ff;
      off_in       = off_ff;
      ramp_time_in = ramp_time_ff;
      total_in     = total_ff;
      left_in      = left_ff;
      pending_in   = pending_ff;
      running_in   = running_ff;
      deadband_in  = csr_we ? csr_wdata : deadband_ff;
      acc_in       = acc_ff;
      rem_in       = rem_ff;
      dvd_in       = dvd_ff;
      neg_in       = neg_ff;
      rsp_acc_in   = rsp_acc_ff;
      rsp_run_in   = rsp_run_ff;
      duty_in      = duty_ff;
      case (cmd.op)
         DP_ACCEPT: begin
            acc_in = 1'b0;
            if (req_opcode == OP_TIMED && req_ok && diff_w > {5'd0, deadband_ff}) begin
               tgt_in[req_idx] = req_pulse_us[WIDTH_W-1:0];
               ramp_time_in    = time_clamped[TIME_W-1:0];
               pending_in      = 1'b1;
               acc_in          = 1'b1;
            end else if (req_opcode == OP_IMMED && req_ok) begin
               cur_in[req_idx] = req_pulse_us[WIDTH_W-1:0];
               tgt_in[req_idx] = req_pulse_us[WIDTH_W-1:0];
               pending_in      = 1'b0;
               acc_in          = 1'b1;
            end
         end
         DP_LATCH: begin
            if (pending_ff) begin
               pending_in = 1'b0;
               total_in   = steps_w;
               left_in    = steps_w;
               running_in = 1'b1;
               for (int i = 0; i < CHANNEL_COUNT; i++) begin
                  off_in[i] = $signed({1'b0, cur_ff[i]}) - $signed({1'b0, tgt_ff[i]});
               end
            end
         end
         DP_STEP: begin
            if (running_ff) begin
               if (left_ff <= STEP_W'(1)) begin
                  left_in    = '0;
                  cur_in     = tgt_ff;
                  running_in = 1'b0;
               end else begin
                  left_in = left_ff - 1'b1;
               end
            end
         end
         DP_MUL: begin
            neg_in = off_ff[ch_idx][OFFSET_W-1];
            rem_in = prod_w[PROD_W-1:WIDTH_W];
            dvd_in = prod_w[WIDTH_W-1:0];
         end
         DP_DIV: begin
            rem_in = div_ge ? STEP_W'(rem2_w - {1'b0, total_ff}) : rem2_w[STEP_W-1:0];
            dvd_in = {dvd_ff[WIDTH_W-2:0], div_ge};
         end
         DP_WRITE: begin
            cur_in[ch_idx] = sat_w;
         end
         DP_LOAD_RSP: begin
            rsp_acc_in = acc_ff;
            rsp_run_in = running_ff;
            for (int i = 0; i < OUT_CHANS; i++) begin
               duty_in[i] = (i < CHANNEL_COUNT) ? cur_ff[i % CHANNEL_COUNT] : '0;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < CHANNEL_COUNT; i++) begin
            cur_ff[i] <= RESET_WIDTH[i];
            tgt_ff[i] <= RESET_WIDTH[i];
            off_ff[i] <= '0;
         end
         ramp_time_ff <= TIME_RESET;
         total_ff     <= '0;
         left_ff      <= '0;
         pending_ff   <= 1'b1;
         running_ff   <= 1'b0;
         deadband_ff  <= DEADBAND_W'(20);
         acc_ff       <= 1'b0;
      end else begin
         cur_ff       <= cur_in;
         tgt_ff       <= tgt_in;
         off_ff       <= off_in;
         ramp_time_ff <= ramp_time_in;
         total_ff     <= total_in;
         left_ff      <= left_in;
         pending_ff   <= pending_in;
         running_ff   <= running_in;
         deadband_ff  <= deadband_in;
         acc_ff       <= acc_in;
      end
   end

   // divider and output payload need no reset
   always_ff @(posedge clock) begin
      rem_ff     <= rem_in;
      dvd_ff     <= dvd_in;
      neg_ff     <= neg_in;
      rsp_acc_ff <= rsp_acc_in;
      rsp_run_ff <= rsp_run_in;
      duty_ff    <= duty_in;
   end

   assign rsp_accepted    = rsp_acc_ff;
   assign rsp_ramp_active = rsp_run_ff;
   assign rsp_duty        = duty_ff;

endmodule

[rtl/servo_timed_linear_ramp.sv]
// top level: servo pulse width linear ramp interpolator
// path to result valid: a set passes through the done state only, a tick with no ramp step to
//    compute passes latch, step and done, and a tick inside a ramp adds, per channel,
//    a multiply, a 12-bit division on the shared restoring divider and a write
// one item in flight; the next request is taken once its result sits in the output register
// synchronous reset: default widths, 2000 ms ramp time, pending change, 20 us deadband
module servo_timed_linear_ramp #(
   parameter int CHANNEL_COUNT = 8
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           csr_we,
   input  logic [str_pkg::DEADBAND_W-1:0] csr_wdata,
   str_req_if.sink                        req_bus,
   str_rsp_if.source                      rsp_bus
);
   import str_pkg::*;

   cmd_type            cmd;
   status_type         status;
   logic [WIDTH_W-1:0] duty [OUT_CHANS];

   str_ctrl #(
      .CHANNEL_COUNT (CHANNEL_COUNT)
   ) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_bus.valid),
      .req_opcode (req_bus.opcode),
      .req_ready  (req_bus.ready),
      .rsp_valid  (rsp_bus.valid),
      .rsp_ready  (rsp_bus.ready),
      .status     (status),
      .cmd        (cmd)
   );

   str_dp #(
      .CHANNEL_COUNT (CHANNEL_COUNT)
   ) u_dp (
      .clock            (clock),
      .reset            (reset),
      .csr_we           (csr_we),
      .csr_wdata        (csr_wdata),
      .req_opcode       (req_bus.opcode),
      .req_channel      (req_bus.channel),
      .req_pulse_us     (req_bus.pulse_us),
      .req_move_time_ms (req_bus.move_time_ms),
      .cmd              (cmd),
      .status           (status),
      .rsp_accepted     (rsp_bus.accepted),
      .rsp_ramp_active  (rsp_bus.ramp_active),
      .rsp_duty         (duty)
   );

   assign rsp_bus.duty_ch0 = duty[0];
   assign rsp_bus.duty_ch1 = duty[1];
   assign rsp_bus.duty_ch2 = duty[2];
   assign rsp_bus.duty_ch3 = duty[3];
   assign rsp_bus.duty_ch4 = duty[4];
   assign rsp_bus.duty_ch5 = duty[5];
   assign rsp_bus.duty_ch6 = duty[6];
   assign rsp_bus.duty_ch7 = duty[7];

endmodule
